FILE: rtl/core/sed_pkg.sv
// Package for the sensor ensemble deframer: result record, hunt phases,
// sync and length constants, and the fixed banner text.
// No dependencies.
package sed_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'h7F;
  localparam logic [16:0] CHECK_BYTES = 17'd2;
  localparam logic [16:0] MIN_TOTAL   = 17'd6;
  localparam int          OFF_W       = 17;
  localparam int          SUM_W       = 16;

  localparam int BANNER_LEN = 32;
  localparam logic [7:0] BANNER_TEXT [BANNER_LEN] = '{
    8'h54, 8'h65, 8'h6C, 8'h65, 8'h64, 8'h79, 8'h6E, 8'h65,
    8'h20, 8'h52, 8'h44, 8'h20, 8'h49, 8'h6E, 8'h73, 8'h74,
    8'h72, 8'h75, 8'h6D, 8'h65, 8'h6E, 8'h74, 8'h73, 8'h20,
    8'h28, 8'h63, 8'h29, 8'h20, 8'h32, 8'h30, 8'h30, 8'h37
  };

  // output queue: a confirming sync byte writes two entries
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_FRAME = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             in_frame;
    logic [OFF_W-1:0] offset;
    logic             frame_end;
    logic             frame_good;
    logic             banner_found;
  } sed_result_t;

endpackage

FILE: rtl/core/sensor_ensemble_deframer.sv
// Top level of the sensor ensemble deframer.
// Uses sed_pkg, sed_banner_cell, sed_frame_ctl and sed_out_fifo.
//
// Input channel: one raw link byte per transaction on in_tdata.
// Output channel: one transaction per input byte, two for the byte that
// confirms a sync pair (the held first 0x7F at offset 0, then offset 1).
// out_tlast marks the last byte of a candidate frame; out_tuser[1] then
// says whether the checksum matched. Bytes outside a frame come out with
// in_frame low and zero data and offset; banner_found is valid on every one.
// Each result is registered in the result queue and shows on the output
// once it reaches its head. Throughput: one byte per cycle while in_tready
// is high; the byte rate is set by the single output port of the 4-entry queue.
// in_tready drops while the queue has fewer than two free entries, so a
// stalled receiver backs up into the input after at most four results.
// Banner matching is a chain of 32 compare cells, one per banner character,
// each passing its match bit to the next cell every accepted byte.
// Reset (synchronous, rst_n low) empties the queue, clears the banner chain
// and returns the frame logic to hunting for the first sync byte.
module sensor_ensemble_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [24:8] byte_offset, [31:25] zero
  output logic        out_tlast,  // frame_end
  output logic [2:0]  out_tuser   // [0] in_frame, [1] frame_good, [2] banner_found
);
  import sed_pkg::*;

  logic                  accept;
  logic [BANNER_LEN:0]   link;
  logic [BANNER_LEN-1:0] hit;
  logic                  banner_hit;
  sed_result_t           res0, res1, rd_d;
  logic                  two_results;

  assign accept     = in_tvalid & in_tready;
  assign link[0]    = 1'b1;
  assign banner_hit = hit[BANNER_LEN-1];

  for (genvar i = 0; i < BANNER_LEN; i++) begin : g_banner
    sed_banner_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (accept),
      .clear    (banner_hit),
      .byte_in  (in_tdata),
      .ref_char (BANNER_TEXT[i]),
      .link_in  (link[i]),
      .hit      (hit[i]),
      .link_out (link[i+1])
    );
  end

  sed_frame_ctl u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_in     (in_tdata),
    .banner_hit  (banner_hit),
    .res0        (res0),
    .res1        (res1),
    .two_results (two_results)
  );

  sed_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_two   (two_results),
    .wr_d0    (res0),
    .wr_d1    (res1),
    .room_two (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_d     (rd_d)
  );

  assign out_tdata = {7'd0, rd_d.offset, rd_d.data};
  assign out_tlast = rd_d.frame_end;
  assign out_tuser = {rd_d.banner_found, rd_d.frame_good, rd_d.in_frame};

  // a full banner match clears the chain, so the last cell never holds a bit
  a_banner_tail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !link[BANNER_LEN]) else $error("banner chain tail set");

  a_end_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0]) else $error("frame end outside frame");

  a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast) else $error("frame good without end");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0) else $error("non-frame data");

  a_pair_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    accept && two_results && !out_tready |=> out_tvalid) else $error("pair lost");

endmodule

FILE: rtl/core/sed_banner_cell.sv
// One cell of the banner matcher chain: holds "banner prefix up to here matched".
// Depends on nothing; the reference character comes in from the top level.
module sed_banner_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       clear,
  input  logic [7:0] byte_in,
  input  logic [7:0] ref_char,
  input  logic       link_in,
  output logic       hit,
  output logic       link_out
);

  logic match_r;
  logic match_nxt;

  assign hit       = link_in & (byte_in == ref_char);
  assign match_nxt = hit & ~clear;
  assign link_out  = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (en) begin
      match_r <= match_nxt;
    end
  end

endmodule

FILE: rtl/core/sed_frame_ctl.sv
// Frame hunter and checker: sync pair search, length capture, byte sum, checksum.
// Produces one or two result records per accepted byte. Uses sed_pkg.
module sed_frame_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  input  logic                banner_hit,
  output sed_pkg::sed_result_t res0,
  output sed_pkg::sed_result_t res1,
  output logic                two_results
);
  import sed_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic [OFF_W-1:0] tot_r, tot_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]       held_r, held_nxt;

  logic [SUM_W-1:0] sum_add;
  logic [OFF_W-1:0] len_total;
  logic [OFF_W:0]   off_plus;

  assign sum_add   = sum_r + {8'd0, byte_in};
  assign len_total = {1'b0, byte_in, held_r} + CHECK_BYTES;
  assign off_plus  = {1'b0, pos_r} + {1'b0, CHECK_BYTES};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      tot_r   <= '0;
      sum_r   <= '0;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tot_r   <= tot_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    tot_nxt     = tot_r;
    sum_nxt     = sum_r;
    held_nxt    = held_r;
    two_results = 1'b0;
    res0        = '0;
    res1        = '0;
    res0.banner_found = banner_hit;

    unique case (phase_r)
      PH_FRAME: begin
        res0.data     = byte_in;
        res0.in_frame = 1'b1;
        res0.offset   = pos_r;
        if (pos_r == OFF_W'(2)) begin
          held_nxt = byte_in;
          sum_nxt  = sum_add;
        end else if (pos_r == OFF_W'(3)) begin
          tot_nxt  = len_total;
          sum_nxt  = sum_add;
          res0.frame_end = (len_total < MIN_TOTAL);
        end else if (off_plus < {1'b0, tot_r}) begin
          sum_nxt = sum_add;
        end else if (off_plus == {1'b0, tot_r}) begin
          held_nxt = byte_in;
        end else begin
          res0.frame_end  = 1'b1;
          res0.frame_good = ({byte_in, held_r} == sum_r);
        end
        if (res0.frame_end) begin
          phase_nxt = PH_HUNT;
        end else begin
          pos_nxt = pos_r + OFF_W'(1);
        end
      end
      PH_SYNC1: begin
        if (byte_in == SYNC_BYTE) begin
          // held first sync byte goes out ahead of the confirming one
          two_results       = 1'b1;
          res0.data         = SYNC_BYTE;
          res0.in_frame     = 1'b1;
          res0.banner_found = 1'b0;
          res1.data         = byte_in;
          res1.in_frame     = 1'b1;
          res1.offset       = OFF_W'(1);
          res1.banner_found = banner_hit;
          phase_nxt = PH_FRAME;
          pos_nxt   = OFF_W'(2);
          sum_nxt   = SUM_W'({8'd0, SYNC_BYTE} + {8'd0, SYNC_BYTE});
          tot_nxt   = '0;
          held_nxt  = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (byte_in == SYNC_BYTE) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
  end

endmodule

FILE: rtl/core/sed_out_fifo.sv
// Small output queue: takes one or two records per cycle, releases one.
// Decouples the result stream from the receiver's tready. Uses sed_pkg.
module sed_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic                wr_two,
  input  sed_pkg::sed_result_t wr_d0,
  input  sed_pkg::sed_result_t wr_d1,
  output logic                room_two,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sed_pkg::sed_result_t rd_d
);
  import sed_pkg::*;

  sed_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] wr_ptr_p1;
  logic               rd_en;
  logic [FIFO_CW-1:0] wr_n;

  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);
  assign rd_valid  = (cnt_r != '0);
  assign rd_en     = rd_valid & rd_ready;
  assign rd_d      = mem[rd_ptr_r];
  assign room_two  = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_n      = wr_en ? (wr_two ? FIFO_CW'(2) : FIFO_CW'(1)) : '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + wr_n[FIFO_AW-1:0];
    rd_ptr_nxt = rd_en ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + wr_n - FIFO_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_d0;
      if (wr_two) begin
        mem[wr_ptr_p1] <= wr_d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for sensor_ensemble_deframer: sync hunt, length and
// checksum framing, banner matching, random idling on both stream sides.
// Depends on sed_pkg and the deframer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [7:0] out_byte, [24:8] byte_offset, [31:25] zero
  logic        out_tlast;           // frame_end
  logic [2:0]  out_tuser;           // [0] in_frame, [1] frame_good, [2] banner_found

  sensor_ensemble_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow of the deframer state, zero after reset
  phase_t      hunt        = PH_HUNT;
  int          frame_pos   = 0;
  int          frame_total = 0;
  logic [15:0] frame_sum   = '0;
  logic [7:0]  held_byte   = '0;
  int          banner_pos  = 0;

  sed_result_t pending_results[$];

  bit idle_en = 1'b1;
  int n_bytes = 0;
  int n_results = 0;
  int n_good_frames = 0;
  int n_bad_frames = 0;
  int n_banners = 0;
  int n_err = 0;

  function automatic void flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic void queue_result(input sed_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Banner matcher: on a mismatch fall back to the longest banner prefix that
  // ends the bytes seen so far; restart from zero after a full match.
  function automatic bit banner_step(input logic [7:0] c);
    int p, k, i, best;
    bit ok, hit;
    hit = 1'b0;
    p = banner_pos;
    if (p >= BANNER_LEN) p = 0;
    if (BANNER_TEXT[p] == c) begin
      p++;
      if (p >= BANNER_LEN) begin
        hit = 1'b1;
        p = 0;
      end
    end else begin
      best = 0;
      for (k = p; k >= 1 && best == 0; k--) begin
        ok = (BANNER_TEXT[k-1] == c);
        for (i = 0; ok && i + 1 < k; i++)
          if (BANNER_TEXT[i] != BANNER_TEXT[p-k+1+i]) ok = 1'b0;
        if (ok) best = k;
      end
      p = best;
    end
    banner_pos = p;
    return hit;
  endfunction

  // Expected results for one accepted link byte
  function automatic void deframe_byte(input logic [7:0] c);
    sed_result_t r;
    bit hit;
    hit = banner_step(c);
    r = '0;
    r.banner_found = hit;
    if (hunt == PH_FRAME) begin
      r.data     = c;
      r.in_frame = 1'b1;
      r.offset   = frame_pos[OFF_W-1:0];
      if (frame_pos == 2) begin
        held_byte = c;
        frame_sum = frame_sum + {8'h00, c};
      end else if (frame_pos == 3) begin
        frame_total = ((int'(c) << 8) | int'(held_byte)) + int'(CHECK_BYTES);
        frame_sum = frame_sum + {8'h00, c};
        if (frame_total < int'(MIN_TOTAL)) r.frame_end = 1'b1;
      end else if (frame_pos + 2 < frame_total) begin
        frame_sum = frame_sum + {8'h00, c};
      end else if (frame_pos + 2 == frame_total) begin
        held_byte = c;
      end else begin
        r.frame_end  = 1'b1;
        r.frame_good = ({c, held_byte} == frame_sum);
      end
      queue_result(r);
      if (r.frame_end) hunt = PH_HUNT;
      else frame_pos++;
    end else if (hunt == PH_SYNC1 && c == SYNC_BYTE) begin
      // the held first sync byte comes out ahead of the confirming one
      r.data         = SYNC_BYTE;
      r.in_frame     = 1'b1;
      r.banner_found = 1'b0;
      queue_result(r);
      r.offset       = OFF_W'(1);
      r.banner_found = hit;
      queue_result(r);
      hunt        = PH_FRAME;
      frame_pos   = 2;
      frame_sum   = {8'h00, SYNC_BYTE} + {8'h00, SYNC_BYTE};
      frame_total = 0;
      held_byte   = '0;
    end else begin
      if (c == SYNC_BYTE) hunt = PH_SYNC1;
      else hunt = PH_HUNT;
      queue_result(r);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    sed_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data         = out_tdata[7:0];
      got.offset       = out_tdata[24:8];
      got.in_frame     = out_tuser[0];
      got.frame_good   = out_tuser[1];
      got.banner_found = out_tuser[2];
      got.frame_end    = out_tlast;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result byte=%02h off=%0d", got.data, got.offset));
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (want.frame_end && want.frame_good) n_good_frames++;
        if (want.frame_end && !want.frame_good) n_bad_frames++;
        if (want.banner_found) n_banners++;
        if (got !== want || out_tdata[31:25] !== '0)
          flag_error({
            $sformatf("result %0d: expected byte=%02h frm=%b off=%0d end=%b good=%b ban=%b,",
              n_results, want.data, want.in_frame, want.offset, want.frame_end,
              want.frame_good, want.banner_found),
            $sformatf(" got byte=%02h frm=%b off=%0d end=%b good=%b ban=%b pad=%02h",
              got.data, got.in_frame, got.offset, got.frame_end, got.frame_good,
              got.banner_found, out_tdata[31:25])});
      end
    end
  end

  // Receiver side: random stall before each transaction
  initial begin : rx_side
    int wait_n;
    while (!rst_n) @(posedge clk);
    forever begin
      wait_n = idle_en ? $urandom_range(0, 5) : 0;
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // in_tvalid stays high after a transaction so back-to-back bytes need no gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    n_bytes++;
  endtask

  task automatic settle_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // len is the header length field; total frame is len + 2 bytes
  task automatic send_frame(input int len, input bit bad_sum, input bit banner_payload);
    logic [15:0] sum;
    logic [7:0]  b;
    int i;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    sum = {8'h00, SYNC_BYTE};
    sum = sum + {8'h00, SYNC_BYTE} + {8'h00, len[7:0]} + {8'h00, len[15:8]};
    if (len < 4) return;  // short length: frame already closed at offset 3
    for (i = 0; i < len - 4; i++) begin
      if (banner_payload && i < BANNER_LEN) b = BANNER_TEXT[i];
      else b = 8'($urandom_range(0, 255));
      sum = sum + {8'h00, b};
      send_byte(b);
    end
    if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
  endtask

  // Noise outside frames; never two sync bytes in a row and never ends on one,
  // so no accidental frame swallows the following stimulus
  task automatic send_noise(input int count);
    logic [7:0] b, prev;
    int i;
    prev = 8'h00;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0:       b = SYNC_BYTE;
        1:       b = BANNER_TEXT[$urandom_range(0, BANNER_LEN - 1)];
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == SYNC_BYTE && (prev == SYNC_BYTE || i == count - 1)) b = ~b;
      send_byte(b);
      prev = b;
    end
  endtask

  task automatic send_banner();
    int i;
    for (i = 0; i < BANNER_LEN; i++) send_byte(BANNER_TEXT[i]);
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);       // broken sync
    send_byte(8'h80);
    send_frame(0, 1'b0, 1'b0);  // short length, smallest
    send_frame(3, 1'b0, 1'b0);  // short length, largest
    send_frame(4, 1'b0, 1'b0);  // minimum frame, good checksum
    send_frame(4, 1'b1, 1'b0);  // minimum frame, bad checksum
  endtask

  task automatic test_banner();
    int i;
    send_banner();
    for (i = 0; i < 4; i++) send_byte(BANNER_TEXT[i]);  // partial then restart
    send_banner();
    send_banner();                                      // back to back
    for (i = 0; i < 20; i++) send_byte(BANNER_TEXT[i]);
    send_byte(8'h00);                                   // mismatch mid-way
    send_banner();
    send_frame(40, 1'b0, 1'b1);                         // banner inside a frame
  endtask

  // Long frame with a nonzero length high byte; run without idling
  task automatic test_long_frame();
    idle_en = 1'b0;
    send_frame(16'h0100, 1'b0, 1'b0);
    idle_en = 1'b1;
  endtask

  task automatic test_random(input int n_items);
    int start, kind, len;
    logic [7:0] b;
    start = n_bytes;
    while (n_bytes - start < n_items) begin
      if ($urandom_range(0, 24) == 0) idle_en = ~idle_en;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 300) : $urandom_range(4, 24);
        send_frame(len, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
      end else if (kind < 68) begin
        send_frame($urandom_range(0, 3), 1'b0, 1'b0);
      end else if (kind < 76) begin
        b = 8'($urandom_range(0, 254));
        if (b >= SYNC_BYTE) b++;
        send_byte(SYNC_BYTE);
        send_byte(b);
      end else if (kind < 81) begin
        send_banner();
      end else if (kind < 84) begin
        settle_results();
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    settle_results();
    test_banner();
    test_long_frame();
    test_random(800);
    settle_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("Run covered %0d link bytes and %0d results: %0d good frames, %0d bad frames,",
             n_bytes, n_results, n_good_frames, n_bad_frames);
    $display("%0d banner hits; %0d errors", n_banners, n_err);
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TIMEOUT with %0d results outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sed_pkg.sv
rtl/core/sed_banner_cell.sv
rtl/core/sed_frame_ctl.sv
rtl/core/sed_out_fifo.sv
rtl/core/sensor_ensemble_deframer.sv
tb/sv/tb.sv
